### hdl/gb_pkg.sv
// Package for the 11x11 Gaussian blur: kernel sizes, pixel widths, types and the
// precomputed Q1.16 coefficient table.
// Depends on nothing; used by the line store, the MAC, the top level and the testbench.
`default_nettype none
package gb_pkg;

    localparam int KERNEL_SIZE = 11;
    localparam int RADIUS      = KERNEL_SIZE / 2;
    localparam int NTAPS       = KERNEL_SIZE * KERNEL_SIZE;
    localparam int COEF_BITS   = 16;
    localparam int COEF_W      = COEF_BITS + 1;
    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int PROD_W      = CH_W + COEF_W;
    localparam int ACC_W       = PROD_W + $clog2(NTAPS);
    localparam int TAP_W       = $clog2(NTAPS);
    localparam int CNT_W       = $clog2(NTAPS + 1);
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int IMG_W_BITS  = 11;
    localparam int IMG_H_BITS  = 12;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_MAC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
    } t_mac_ctl;

    typedef logic [COEF_W-1:0] t_coef_tab [NTAPS];

    localparam longint unsigned GAUSS_Q16 [8] = '{
        64'd65536, 64'd61994, 64'd52477, 64'd39750,
        64'd26943, 64'd16342, 64'd8869,  64'd4308
    };

    function automatic longint unsigned tap_weight(int k);
        int d;
        d = k - RADIUS;
        if (d < 0) begin
            d = -d;
        end
        return GAUSS_Q16[d & 7];
    endfunction

    function automatic longint unsigned weight_sum();
        longint unsigned t;
        t = 0;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            t = t + tap_weight(k);
        end
        return t;
    endfunction

    localparam longint unsigned WSUM = weight_sum();
    localparam longint unsigned NORM = WSUM * WSUM;

    function automatic t_coef_tab make_coefs();
        t_coef_tab tab;
        longint unsigned num;
        for (int i = 0; i < NTAPS; i++) begin
            num = (tap_weight(i / KERNEL_SIZE) * tap_weight(i % KERNEL_SIZE)) << COEF_BITS;
            tab[i] = COEF_W'((num + NORM / 2) / NORM);
        end
        return tab;
    endfunction

    localparam t_coef_tab COEF_TAB = make_coefs();

endpackage
`default_nettype wire

### hdl/gb_line_mem.sv
// Line store: one word per column holding the last KERNEL_SIZE-1 rows of RGB.
// Read one cycle after the address, written back shifted up by one row.
// Depends on gb_pkg.
`default_nettype none
module gb_line_mem #(
    parameter int MAX_WIDTH = gb_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]                  i_addr,
    input  wire logic                                          i_wr_en,
    input  wire logic [gb_pkg::PIX_W-1:0]                      i_pix,
    output logic [(gb_pkg::KERNEL_SIZE-1)*gb_pkg::PIX_W-1:0]   o_col
);
    import gb_pkg::*;

    localparam int WORD_W = (KERNEL_SIZE - 1) * PIX_W;

    logic [WORD_W-1:0]              r_mem [MAX_WIDTH];
    logic [$clog2(MAX_WIDTH)-1:0]   r_addr;
    logic [WORD_W-1:0]              n_word;

    assign n_word = {i_pix, o_col[WORD_W-1:PIX_W]};

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_addr <= i_addr;
            o_col  <= r_mem[i_addr];
        end
        if (i_wr_en) begin
            r_mem[r_addr] <= n_word;
        end
    end

endmodule
`default_nettype wire

### hdl/gb_mac.sv
// Window registers and a shared multiply-accumulate per channel; the window
// rotates once around so each tap meets its coefficient in turn.
// Depends on gb_pkg.
`default_nettype none
module gb_mac (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire gb_pkg::t_mac_ctl                          i_ctl,
    input  wire logic [gb_pkg::KERNEL_SIZE*gb_pkg::PIX_W-1:0] i_col,
    output logic                                           o_done,
    output logic [2:0][gb_pkg::ACC_W-1:0]                  o_acc
);
    import gb_pkg::*;

    logic [PIX_W-1:0]             r_win [NTAPS];
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;
    logic                         r_pv;
    logic [2:0][PROD_W-1:0]       r_prod;
    logic                         rot;

    assign rot = r_busy && (r_cnt != CNT_W'(NTAPS));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int a = 0; a < KERNEL_SIZE; a++) begin
                for (int b = 0; b < KERNEL_SIZE - 1; b++) begin
                    r_win[a*KERNEL_SIZE+b] <= r_win[a*KERNEL_SIZE+b+1];
                end
                r_win[a*KERNEL_SIZE+KERNEL_SIZE-1] <= i_col[a*PIX_W +: PIX_W];
            end
        end else if (rot) begin
            for (int i = 0; i < NTAPS; i++) begin
                r_win[i] <= r_win[(i + 1) % NTAPS];
            end
        end
        if (rot) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= PROD_W'(r_win[0][c*CH_W +: CH_W] * COEF_TAB[r_cnt[TAP_W-1:0]]);
            end
        end
        if (i_ctl.start) begin
            o_acc <= '0;
        end else if (r_pv) begin
            for (int c = 0; c < 3; c++) begin
                o_acc[c] <= o_acc[c] + ACC_W'(r_prod[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_pv   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_pv   <= rot;
            o_done <= r_busy && !rot;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (rot) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### hdl/gaussian_blur_11x11_rgb.sv
// 11x11 Gaussian blur (sigma 3) on an RGB pixel stream in raster order. One
// result per interior pixel; pixels whose window leaves the frame give none,
// and frame_last marks the result of the frame's last pixel. A pixel that gives
// no result passes through the line store read and write back; an interior pixel
// passes the read and the load, then one multiplier per channel walks the 121
// window taps, then the product and accumulate registers, the done flag and the
// result register, and waits longer while an earlier result still waits
// unaccepted. A finished result waits in the output register while the next
// pixel is taken. The line store needs no clearing after reset. Depends on
// gb_pkg, gb_line_mem and gb_mac.
`default_nettype none
module gaussian_blur_11x11_rgb #(
    parameter int MAX_WIDTH = gb_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  wire logic [23:0]                   i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic [23:0]                        o_m_axis_tdata,
    // frame_last
    output logic                               o_m_axis_tlast,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [gb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gb_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    t_state                              r_state, n_state;
    t_mac_ctl                            ctl;
    logic [COL_W-1:0]                    r_col;
    logic [IMG_H_BITS-1:0]               r_row;
    logic [IMG_W_BITS-1:0]               r_width;
    logic [IMG_H_BITS-1:0]               r_height;
    logic [PIX_W-1:0]                    r_pix;
    logic                                r_prod;
    logic                                r_last;
    logic                                r_ovalid;
    logic [23:0]                         r_odata;
    logic                                r_olast;
    logic                                accept;
    logic                                out_free;
    logic                                mac_done;
    logic [2:0][ACC_W-1:0]               acc;
    logic [(KERNEL_SIZE-1)*PIX_W-1:0]    col_word;
    logic [COL_W-1:0]                    w_last;
    logic [IMG_H_BITS-1:0]               h_last;
    logic                                col_end;
    logic                                row_end;

    function automatic logic [CH_W-1:0] sat8(logic [ACC_W-1:0] a);
        logic [ACC_W-COEF_BITS-1:0] v;
        v = a[ACC_W-1:COEF_BITS];
        return (v > (ACC_W - COEF_BITS)'(255)) ? CH_W'(255) : v[CH_W-1:0];
    endfunction

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

    always_comb begin
        if (r_width == '0) begin
            w_last = '0;
        end else if ({2'b0, r_width} > (IMG_W_BITS + 2)'(MAX_WIDTH)) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_W'(r_width - 1'b1);
        end
        h_last  = (r_height == '0) ? '0 : r_height - 1'b1;
        col_end = ({1'b0, r_col} >= (COL_W + 1)'(w_last));
        row_end = (r_row >= h_last);
    end

    gb_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
        .i_clk   (i_clk),
        .i_rd_en (accept),
        .i_addr  (r_col),
        .i_wr_en (ctl.load),
        .i_pix   (r_pix),
        .o_col   (col_word)
    );

    gb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_col   ({r_pix, col_word}),
        .o_done  (mac_done),
        .o_acc   (acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        ctl.load  = 1'b0;
        ctl.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                ctl.load  = 1'b1;
                ctl.start = r_prod;
                n_state   = r_prod ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                if (mac_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_width  <= IMG_W_BITS'(512);
            r_height <= IMG_H_BITS'(512);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH:  r_width  <= i_cfg_data[IMG_W_BITS-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[IMG_H_BITS-1:0];
                    default:    r_width  <= r_width;
                endcase
            end
            if (accept) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix  <= {i_s_axis_tdata[7:0], i_s_axis_tdata[15:8], i_s_axis_tdata[23:16]};
            r_prod <= (r_row >= IMG_H_BITS'(KERNEL_SIZE - 1))
                   && ({1'b0, r_col} >= (COL_W + 1)'(KERNEL_SIZE - 1));
            r_last <= row_end && col_end;
        end
        if (r_state == S_FIN && out_free) begin
            r_odata <= {sat8(acc[0]), sat8(acc[1]), sat8(acc[2])};
            r_olast <= r_last;
        end
    end

endmodule
`default_nettype wire

### hdl/gb_checker.sv
// Port-level checks for the Gaussian blur top level, bound to every instance.
// Depends on gaussian_blur_11x11_rgb.
`default_nettype none
module gb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output beat valid after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
            && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while previous beat in work");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !$rose(o_m_axis_tvalid) ##1
            !$rose(o_m_axis_tvalid))
        else $error("result appeared too soon after input beat");

endmodule

bind gaussian_blur_11x11_rgb gb_checker u_gb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire

### dv/tb_gaussian_blur_11x11_rgb.sv
// Testbench for gaussian_blur_11x11_rgb: drives pixel frames of several sizes,
// predicts each blurred interior pixel with a scoreboard class, checks every result beat.
// Depends on gb_pkg and the blur RTL.
`timescale 1ns / 100ps
module tb_gaussian_blur_11x11_rgb;
    import gb_pkg::*;

    localparam int K        = 11;
    localparam int MAXW     = 1024;
    localparam int SETTLE   = 200;
    localparam longint LIMIT = 3000000;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } t_rgb;

    typedef struct {
        t_rgb pix;
        bit   last;
    } t_blur_res;

    class blur_scoreboard;
        t_rgb        lines [K-1][MAXW];
        t_rgb        win [K][K];
        longint      coef [K][K];
        int unsigned col, row, width, height;
        t_blur_res   blurred_q [$];
        int          n_pix, n_res;

        function new();
            longint e [8] = '{65536, 61994, 52477, 39750, 26943, 16342, 8869, 4308};
            longint t, s, wa, wb;
            t = 0;
            for (int k = 0; k < K; k++) t += e[k > 5 ? k - 5 : 5 - k];
            s = t * t;
            for (int a = 0; a < K; a++) begin
                for (int c = 0; c < K; c++) begin
                    wa = e[a > 5 ? a - 5 : 5 - a];
                    wb = e[c > 5 ? c - 5 : 5 - c];
                    coef[a][c] = (((wa * wb) << 16) + s / 2) / s;
                end
            end
            foreach (lines[i, j]) lines[i][j] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            col = 0; row = 0; width = 512; height = 512;
            n_pix = 0; n_res = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [11:0] v);
            if (idx == CFG_WIDTH) width = v[10:0];
            else height = v;
        endfunction

        function bit at_frame_start();
            return col == 0 && row == 0;
        endfunction

        function void note_pixel(t_rgb p);
            t_rgb        colv [K];
            int unsigned w, h, c;
            longint      ar, ag, ab;
            bit          produce, last;
            t_blur_res   res;
            w = width < 1 ? 1 : (width > MAXW ? MAXW : width);
            h = height < 1 ? 1 : height;
            c = col >= MAXW ? MAXW - 1 : col;
            n_pix++;
            for (int a = 0; a < K - 1; a++) colv[a] = lines[a][c];
            colv[K-1] = p;
            for (int a = 0; a < K; a++) begin
                for (int j = 0; j < K - 1; j++) win[a][j] = win[a][j+1];
                win[a][K-1] = colv[a];
            end
            for (int a = 0; a < K - 2; a++) lines[a][c] = lines[a+1][c];
            lines[K-2][c] = p;
            produce = row >= K - 1 && c >= K - 1;
            last = row >= h - 1 && c >= w - 1;
            if (c >= w - 1) begin
                col = 0;
                row = row >= h - 1 ? 0 : row + 1;
            end else begin
                col = c + 1;
            end
            if (!produce) return;
            ar = 0; ag = 0; ab = 0;
            for (int a = 0; a < K; a++) begin
                for (int j = 0; j < K; j++) begin
                    ar += longint'(win[a][j].r) * coef[a][j];
                    ag += longint'(win[a][j].g) * coef[a][j];
                    ab += longint'(win[a][j].b) * coef[a][j];
                end
            end
            res.pix.r = (ar >> 16) > 255 ? 8'd255 : 8'(ar >> 16);
            res.pix.g = (ag >> 16) > 255 ? 8'd255 : 8'(ag >> 16);
            res.pix.b = (ab >> 16) > 255 ? 8'd255 : 8'(ab >> 16);
            res.last = last;
            blurred_q.push_back(res);
        endfunction

        function bit check_result(t_rgb p, bit last, output string msg);
            t_blur_res x;
            msg = "";
            n_res++;
            if (blurred_q.size() == 0) begin
                msg = $sformatf("result beat %0d with none expected", n_res);
                return 0;
            end
            x = blurred_q.pop_front();
            if (p.r != x.pix.r) msg = {msg, $sformatf(" red %0d/%0d", p.r, x.pix.r)};
            if (p.g != x.pix.g) msg = {msg, $sformatf(" green %0d/%0d", p.g, x.pix.g)};
            if (p.b != x.pix.b) msg = {msg, $sformatf(" blue %0d/%0d", p.b, x.pix.b)};
            if (last != x.last) msg = {msg, $sformatf(" last %0d/%0d", last, x.last)};
            if (msg != "") msg = {$sformatf("result beat %0d got/exp:", n_res), msg};
            return msg == "";
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_valid = 0;
    logic [23:0] s_data = '0;
    logic        m_ready = 0;
    logic        cfg_valid = 0;
    t_cfg_idx    cfg_index = CFG_WIDTH;
    logic [11:0] cfg_data = '0;
    wire         s_ready, m_valid, m_last, cfg_ready;
    wire  [23:0] m_data;

    gaussian_blur_11x11_rgb dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .o_m_axis_tdata(m_data),
        .o_m_axis_tlast(m_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    blur_scoreboard sb = new();
    int     n_err = 0;
    int     burst_left = 0;
    int     n_frames = 0;
    longint cyc = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    task automatic report(string msg);
        n_err++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        string msg;
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("tb_gaussian_blur_11x11_rgb: done, errors");
            $finish;
        end
        if (m_valid && m_ready && !sb.check_result(m_data, m_last, msg)) report(msg);
        if (cyc[10:9] == 0) m_ready <= 1;
        else if (cyc[10:9] == 1) m_ready <= ($urandom_range(0, 9) != 0);
        else m_ready <= ($urandom_range(0, 2) != 0);
    end

    task automatic send_pixel(t_rgb p);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
        end
        s_valid <= 1;
        s_data <= p;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sb.note_pixel(p);
        burst_left--;
    endtask

    task automatic wait_idle();
        s_valid <= 0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.blurred_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [11:0] v);
        wait_idle();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, v);
        cfg_valid <= 0;
    endtask

    // pattern: 0 random, 1 all white, 2 all black, 3 checkerboard
    task automatic finish_frame(int pattern);
        t_rgb p;
        do begin
            case (pattern)
                1: p = '1;
                2: p = '0;
                3: p = ((sb.col ^ sb.row) & 1) ? '1 : '0;
                default: p = 24'($urandom());
            endcase
            send_pixel(p);
        end while (!sb.at_frame_start());
        n_frames++;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // smallest frame that yields a result
        write_cfg(CFG_WIDTH, 12'd11);
        write_cfg(CFG_HEIGHT, 12'd11);
        finish_frame(1);
        finish_frame(2);
        finish_frame(3);

        // zero registers clamp to one
        write_cfg(CFG_WIDTH, 12'd0);
        write_cfg(CFG_HEIGHT, 12'd0);
        repeat (20) finish_frame(0);

        // too narrow: no results
        write_cfg(CFG_WIDTH, 12'd5);
        write_cfg(CFG_HEIGHT, 12'd30);
        finish_frame(0);

        // tallest height, then shrink mid-frame
        write_cfg(CFG_WIDTH, 12'd11);
        write_cfg(CFG_HEIGHT, 12'd4095);
        repeat (22) send_pixel(24'($urandom()));
        write_cfg(CFG_HEIGHT, 12'd11);
        finish_frame(0);

        // shrink height past the current row: row count wraps
        write_cfg(CFG_WIDTH, 12'd12);
        write_cfg(CFG_HEIGHT, 12'd16);
        repeat (13 * 12) send_pixel(24'($urandom()));
        write_cfg(CFG_HEIGHT, 12'd12);
        finish_frame(0);

        // random small frames
        while (sb.n_pix < 1000) begin
            write_cfg(CFG_WIDTH, 12'($urandom_range(11, 20)));
            write_cfg(CFG_HEIGHT, 12'($urandom_range(11, 16)));
            finish_frame(0);
        end

        // width register with every bit set, then shrink mid-row: column wraps
        write_cfg(CFG_WIDTH, 12'hFFF);
        write_cfg(CFG_HEIGHT, 12'd0);
        repeat (30) send_pixel(24'($urandom()));
        write_cfg(CFG_WIDTH, 12'd11);
        finish_frame(0);

        wait_idle();
        $display("covered %0d frames, %0d pixels, %0d blurred results", n_frames,
                 sb.n_pix, sb.n_res);
        $display("widths 0 to all ones clamped, heights 0..4095, mid-frame shrinks");
        if (n_err == 0) begin
            $display("tb_gaussian_blur_11x11_rgb: done, clean");
        end else begin
            $display("tb_gaussian_blur_11x11_rgb: done, errors");
        end
        $finish;
    end
endmodule
